>>> hdl/inclusive_three_level_fifo_cache_unit_defines.svh
// Assertion macros shared by the cache unit RTL
`ifndef INCLUSIVE_THREE_LEVEL_FIFO_CACHE_UNIT_DEFINES_SVH
`define INCLUSIVE_THREE_LEVEL_FIFO_CACHE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITFC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ITFC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/itfc_pkg.sv
// Shared types and constants of the three-level FIFO cache unit
`default_nettype none
package itfc_pkg;

	localparam int LINE_W = 58;

	localparam logic [1:0] HIT_MISS = 2'd0;
	localparam logic [1:0] HIT_L1   = 2'd1;
	localparam logic [1:0] HIT_L2   = 2'd2;
	localparam logic [1:0] HIT_L3   = 2'd3;

	typedef logic [LINE_W-1:0] line_t;

	typedef enum logic [2:0] {
		LOP_NONE,
		LOP_READ,
		LOP_FILL,
		LOP_REMOVE,
		LOP_CLEAR
	} lvl_op_t;

	typedef struct packed {
		lvl_op_t op;
		line_t   key;
	} lvl_req_t;

	typedef struct packed {
		logic  hit;
		logic  victim_valid;
		line_t victim_line;
	} lvl_rsp_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK_RD,
		ST_LOOK,
		ST_F3,
		ST_I2_RD,
		ST_I2,
		ST_I1A_RD,
		ST_I1A,
		ST_F2_RD,
		ST_F2,
		ST_I1B_RD,
		ST_I1B,
		ST_F1_RD,
		ST_F1,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> hdl/itfc_level.sv
// One cache level: set-row memory, row register and per-way FIFO update logic
`default_nettype none
module itfc_level #(
	parameter int SETS = 64,
	parameter int WAYS = 12
) (
	input  wire logic                                   clk,
	input  wire logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] addr,
	input  wire itfc_pkg::lvl_req_t                     req,
	output      itfc_pkg::lvl_rsp_t                     rsp
);
	import itfc_pkg::*;

	localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [WAYS-1:0]              vld_mem  [SETS];
	logic [WAYS-1:0][AW-1:0]      age_mem  [SETS];
	logic [WAYS-1:0][LINE_W-1:0]  line_mem [SETS];

	logic [WAYS-1:0]              vld_q;
	logic [WAYS-1:0][AW-1:0]      age_q;
	logic [WAYS-1:0][LINE_W-1:0]  row_q;

	logic [WAYS-1:0]              hit_vec;
	logic [WAYS-1:0]              old_vec;
	logic [WAYS-1:0]              keep_vec;
	logic [WAYS-1:0]              free_vec;
	logic [WAYS-1:0]              slot_vec;
	logic                         full;
	logic [AW-1:0]                rm_age;
	line_t                        vic_line;

	logic                         wr_en;
	logic [WAYS-1:0]              vld_d;
	logic [WAYS-1:0][AW-1:0]      age_d;
	logic [WAYS-1:0][LINE_W-1:0]  row_d;

	always_comb begin
		full     = &vld_q;
		rm_age   = '0;
		vic_line = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = vld_q[w] && (row_q[w] == req.key);
			old_vec[w] = vld_q[w] && (age_q[w] == AW'(WAYS - 1));
			if (old_vec[w])
				vic_line = vic_line | row_q[w];
			if (hit_vec[w])
				rm_age = rm_age | age_q[w];
		end
		// drop the oldest way first when the set is full; its removal ages nobody
		keep_vec = full ? (vld_q & ~old_vec) : vld_q;
		free_vec = ~keep_vec;
		slot_vec = free_vec & (~free_vec + 1'b1);

		wr_en = 1'b0;
		vld_d = vld_q;
		age_d = age_q;
		row_d = row_q;
		unique case (req.op)
			LOP_FILL: begin
				wr_en = 1'b1;
				vld_d = keep_vec | slot_vec;
				for (int w = 0; w < WAYS; w++) begin
					if (slot_vec[w]) begin
						age_d[w] = '0;
						row_d[w] = req.key;
					end else if (keep_vec[w]) begin
						age_d[w] = AW'(age_q[w] + 1'b1);
					end
				end
			end
			LOP_REMOVE: begin
				wr_en = |hit_vec;
				vld_d = vld_q & ~hit_vec;
				for (int w = 0; w < WAYS; w++) begin
					if (vld_q[w] && (age_q[w] > rm_age))
						age_d[w] = AW'(age_q[w] - 1'b1);
				end
			end
			LOP_CLEAR: begin
				wr_en = 1'b1;
				vld_d = '0;
				age_d = '0;
			end
			LOP_NONE, LOP_READ: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vld_mem[addr]  <= vld_d;
			age_mem[addr]  <= age_d;
			line_mem[addr] <= row_d;
		end
		if (req.op == LOP_READ) begin
			vld_q <= vld_mem[addr];
			age_q <= age_mem[addr];
			row_q <= line_mem[addr];
		end
	end

	assign rsp.hit          = |hit_vec;
	assign rsp.victim_valid = full;
	assign rsp.victim_line  = vic_line;

endmodule
`default_nettype wire

>>> hdl/inclusive_three_level_fifo_cache_unit.sv
// Top level of the three-level inclusive FIFO cache unit
`default_nettype none
`include "inclusive_three_level_fifo_cache_unit_defines.svh"
// Looks up one line number per beat in three inclusive set-associative levels with FIFO
// replacement, fills missing levels from L3 inward, back-invalidates L3 and L2 victims,
// and returns the hit level and any L3 victim. Set counts are powers of two, so the set
// index of each level is the low bits of the line number. After reset the unit clears
// the valid bits of all levels, one set row a cycle, until every set of the largest
// level (32768 with the default parameters) is clear; no beat is taken meanwhile. Every
// level step reads a set row into a register and compares and writes it back in the
// next cycle. An L1 hit needs only the lookup step; lower hits and misses add fill steps
// and each L3 or L2 victim adds back-invalidation steps. One item is in the unit at a
// time; a finished result waits in the output register while the next beat is taken,
// and a stalled result holds the unit until the register frees.
module inclusive_three_level_fifo_cache_unit #(
	parameter int FIRST_SETS  = 64,
	parameter int FIRST_WAYS  = 12,
	parameter int SECOND_SETS = 1024,
	parameter int SECOND_WAYS = 20,
	parameter int THIRD_SETS  = 32768,
	parameter int THIRD_WAYS  = 12
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_stall,
	input  wire itfc_pkg::line_t line_number,
	output      logic            out_valid,
	input  wire logic            out_stall,
	output      logic [1:0]      hit_level,
	output      logic            victim_valid,
	output      itfc_pkg::line_t victim_line
);
	import itfc_pkg::*;

	localparam int SW1   = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 1;
	localparam int SW2   = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 1;
	localparam int SW3   = (THIRD_SETS > 1) ? $clog2(THIRD_SETS) : 1;
	localparam int MAX12 = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
	localparam int MAXS  = (MAX12 > THIRD_SETS) ? MAX12 : THIRD_SETS;
	localparam int CW    = (MAXS > 1) ? $clog2(MAXS) : 1;

	state_t          state_q, state_d;
	logic [CW-1:0]   clr_q;
	logic            out_valid_q;

	line_t           line_q, v3_q, v2_q;
	logic            v3_vld_q;
	logic [1:0]      lvl_q;
	logic [1:0]      hit_level_q;
	logic            victim_valid_q;
	line_t           victim_line_q;

	lvl_req_t        req1, req2, req3;
	lvl_rsp_t        rsp1, rsp2, rsp3;
	logic [SW1-1:0]  addr1;
	logic [SW2-1:0]  addr2;
	logic [SW3-1:0]  addr3;

	logic [SW1-1:0]  ln_set1, v3_set1, v2_set1;
	logic [SW2-1:0]  ln_set2, v3_set2;
	logic [SW3-1:0]  ln_set3;
	logic            accept;
	logic            out_free;

	// set index is the low bits of the line; a single set has index zero
	assign ln_set1 = (FIRST_SETS > 1) ? line_q[SW1-1:0] : '0;
	assign ln_set2 = (SECOND_SETS > 1) ? line_q[SW2-1:0] : '0;
	assign ln_set3 = (THIRD_SETS > 1) ? line_q[SW3-1:0] : '0;
	assign v3_set1 = (FIRST_SETS > 1) ? v3_q[SW1-1:0] : '0;
	assign v3_set2 = (SECOND_SETS > 1) ? v3_q[SW2-1:0] : '0;
	assign v2_set1 = (FIRST_SETS > 1) ? v2_q[SW1-1:0] : '0;

	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		req1.op   = LOP_NONE;
		req2.op   = LOP_NONE;
		req3.op   = LOP_NONE;
		req1.key  = line_q;
		req2.key  = line_q;
		req3.key  = line_q;
		addr1     = ln_set1;
		addr2     = ln_set2;
		addr3     = ln_set3;
		unique case (state_q)
			ST_CLEAR: begin
				addr1 = clr_q[SW1-1:0];
				addr2 = clr_q[SW2-1:0];
				addr3 = clr_q[SW3-1:0];
				if ({1'b0, clr_q} < (CW+1)'(FIRST_SETS))
					req1.op = LOP_CLEAR;
				if ({1'b0, clr_q} < (CW+1)'(SECOND_SETS))
					req2.op = LOP_CLEAR;
				if ({1'b0, clr_q} < (CW+1)'(THIRD_SETS))
					req3.op = LOP_CLEAR;
				if (clr_q == CW'(MAXS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = ST_LOOK_RD;
			end
			ST_LOOK_RD: begin
				req1.op = LOP_READ;
				req2.op = LOP_READ;
				req3.op = LOP_READ;
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				priority if (rsp1.hit)
					state_d = ST_DONE;
				else if (rsp2.hit)
					state_d = ST_F1_RD;
				else if (rsp3.hit)
					state_d = ST_F2_RD;
				else
					state_d = ST_F3;
			end
			ST_F3: begin
				req3.op = LOP_FILL;
				state_d = rsp3.victim_valid ? ST_I2_RD : ST_F2_RD;
			end
			ST_I2_RD: begin
				req2.op = LOP_READ;
				addr2   = v3_set2;
				state_d = ST_I2;
			end
			ST_I2: begin
				req2.op  = LOP_REMOVE;
				req2.key = v3_q;
				addr2    = v3_set2;
				state_d  = ST_I1A_RD;
			end
			ST_I1A_RD: begin
				req1.op = LOP_READ;
				addr1   = v3_set1;
				state_d = ST_I1A;
			end
			ST_I1A: begin
				req1.op  = LOP_REMOVE;
				req1.key = v3_q;
				addr1    = v3_set1;
				state_d  = ST_F2_RD;
			end
			ST_F2_RD: begin
				req2.op = LOP_READ;
				state_d = ST_F2;
			end
			ST_F2: begin
				req2.op = LOP_FILL;
				state_d = rsp2.victim_valid ? ST_I1B_RD : ST_F1_RD;
			end
			ST_I1B_RD: begin
				req1.op = LOP_READ;
				addr1   = v2_set1;
				state_d = ST_I1B;
			end
			ST_I1B: begin
				req1.op  = LOP_REMOVE;
				req1.key = v2_q;
				addr1    = v2_set1;
				state_d  = ST_F1_RD;
			end
			ST_F1_RD: begin
				req1.op = LOP_READ;
				state_d = ST_F1;
			end
			ST_F1: begin
				req1.op = LOP_FILL;
				state_d = ST_DONE;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= CW'(clr_q + 1'b1);
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q   <= line_number;
			v3_vld_q <= 1'b0;
			v3_q     <= '0;
		end
		if (state_q == ST_LOOK) begin
			priority if (rsp1.hit)
				lvl_q <= HIT_L1;
			else if (rsp2.hit)
				lvl_q <= HIT_L2;
			else if (rsp3.hit)
				lvl_q <= HIT_L3;
			else
				lvl_q <= HIT_MISS;
		end
		if (state_q == ST_F3 && rsp3.victim_valid) begin
			v3_vld_q <= 1'b1;
			v3_q     <= rsp3.victim_line;
		end
		if (state_q == ST_F2)
			v2_q <= rsp2.victim_line;
		if (state_q == ST_DONE && out_free) begin
			hit_level_q    <= lvl_q;
			victim_valid_q <= v3_vld_q;
			victim_line_q  <= v3_q;
		end
	end

	itfc_level #(.SETS(FIRST_SETS), .WAYS(FIRST_WAYS)) u_l1 (
		.clk  (clk),
		.addr (addr1),
		.req  (req1),
		.rsp  (rsp1)
	);

	itfc_level #(.SETS(SECOND_SETS), .WAYS(SECOND_WAYS)) u_l2 (
		.clk  (clk),
		.addr (addr2),
		.req  (req2),
		.rsp  (rsp2)
	);

	itfc_level #(.SETS(THIRD_SETS), .WAYS(THIRD_WAYS)) u_l3 (
		.clk  (clk),
		.addr (addr3),
		.req  (req3),
		.rsp  (rsp3)
	);

	assign out_valid    = out_valid_q;
	assign hit_level    = hit_level_q;
	assign victim_valid = victim_valid_q;
	assign victim_line  = victim_line_q;

	`ITFC_ASSERT_IMP(a_clear_quiet, state_q == ST_CLEAR, !out_valid_q, "result beat during clear")
	`ITFC_ASSERT_IMP(a_victim_on_miss, out_valid_q && victim_valid_q, hit_level_q == HIT_MISS, "L3 victim without a miss")
	`ITFC_ASSERT_IMP(a_victim_zero, out_valid_q && !victim_valid_q, victim_line_q == '0, "victim line not zero")
	`ITFC_ASSERT_IMP(a_done_path, state_q == ST_DONE && $past(state_q) != ST_DONE, lvl_q == HIT_L1 || $past(state_q) == ST_F1, "result without L1 fill")
	`ITFC_ASSERT_NXT(a_result_load, state_q == ST_DONE && !out_valid_q, out_valid_q && hit_level_q == $past(lvl_q), "result not loaded")

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the three-level inclusive FIFO cache unit
`timescale 1ns / 100ps

module tb;
	import itfc_pkg::*;

	typedef struct {
		logic [1:0] level;
		logic       vvalid;
		line_t      vline;
	} cache_outcome_t;

	class cache_scoreboard;
		line_t          tag_mem[];
		bit             vld_mem[];
		byte unsigned   age_mem[];
		int             off[3];
		int             sets[3];
		int             ways[3];
		cache_outcome_t outcome_q[$];
		int             errors;

		function new();
			sets = '{64, 1024, 32768};
			ways = '{12, 20, 12};
			off  = '{0, 768, 768 + 20480};
			tag_mem = new[768 + 20480 + 393216];
			vld_mem = new[768 + 20480 + 393216];
			age_mem = new[768 + 20480 + 393216];
			errors = 0;
		endfunction

		function int set_base(int l, line_t line);
			return off[l] + int'(line % line_t'(sets[l])) * ways[l];
		endfunction

		function int find_way(int l, line_t line);
			int b;
			b = set_base(l, line);
			for (int w = 0; w < ways[l]; w++)
				if (vld_mem[b + w] && tag_mem[b + w] == line / line_t'(sets[l]))
					return w;
			return -1;
		endfunction

		function void drop_way(int l, int b, int way);
			byte unsigned a;
			a = age_mem[b + way];
			vld_mem[b + way] = 0;
			for (int w = 0; w < ways[l]; w++)
				if (vld_mem[b + w] && age_mem[b + w] > a)
					age_mem[b + w]--;
		endfunction

		function void back_invalidate(int l, line_t line);
			int w;
			w = find_way(l, line);
			if (w >= 0)
				drop_way(l, set_base(l, line), w);
		endfunction

		// insert a line, evicting the oldest way of a full set
		function bit insert_line(int l, line_t line, output line_t victim);
			int b, cnt, oldest, slot;
			bit ev;
			b = set_base(l, line);
			cnt = 0;
			oldest = 0;
			slot = 0;
			ev = 0;
			victim = '0;
			for (int w = 0; w < ways[l]; w++)
				if (vld_mem[b + w]) begin
					if (cnt == 0 || age_mem[b + w] > age_mem[b + oldest])
						oldest = w;
					cnt++;
				end
			if (cnt >= ways[l]) begin
				victim = tag_mem[b + oldest] * line_t'(sets[l]) + (line % line_t'(sets[l]));
				drop_way(l, b, oldest);
				ev = 1;
			end
			for (int w = ways[l]; w > 0; w--)
				if (!vld_mem[b + w - 1])
					slot = w - 1;
			for (int w = 0; w < ways[l]; w++)
				if (vld_mem[b + w])
					age_mem[b + w]++;
			tag_mem[b + slot] = line / line_t'(sets[l]);
			vld_mem[b + slot] = 1;
			age_mem[b + slot] = 0;
			return ev;
		endfunction

		function void note_access(line_t line);
			cache_outcome_t r;
			line_t v3, v2, v1;
			bit ev2;
			r.vvalid = 0;
			r.vline = '0;
			if (find_way(0, line) >= 0)
				r.level = HIT_L1;
			else if (find_way(1, line) >= 0)
				r.level = HIT_L2;
			else if (find_way(2, line) >= 0)
				r.level = HIT_L3;
			else
				r.level = HIT_MISS;
			if (r.level == HIT_MISS) begin
				r.vvalid = insert_line(2, line, v3);
				if (r.vvalid) begin
					r.vline = v3;
					back_invalidate(1, v3);
					back_invalidate(0, v3);
				end
			end
			if (r.level == HIT_MISS || r.level == HIT_L3) begin
				ev2 = insert_line(1, line, v2);
				if (ev2)
					back_invalidate(0, v2);
			end
			if (r.level != HIT_L1)
				void'(insert_line(0, line, v1));
			outcome_q.push_back(r);
		endfunction

		function void check_result(logic [1:0] level, logic vvalid, line_t vline);
			cache_outcome_t e;
			if (outcome_q.size() == 0) begin
				$error("result beat with no access outstanding");
				errors++;
				return;
			end
			e = outcome_q.pop_front();
			if (level !== e.level) begin
				$error("hit_level expected %0d actual %0d", e.level, level);
				errors++;
			end
			if (vvalid !== e.vvalid) begin
				$error("victim_valid expected %0d actual %0d", e.vvalid, vvalid);
				errors++;
			end
			if (vline !== e.vline) begin
				$error("victim_line expected %h actual %h", e.vline, vline);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	line_t      line_number;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] hit_level;
	logic       victim_valid;
	line_t      victim_line;

	cache_scoreboard sb;
	bit              calm;
	line_t           tag_pool[24];
	logic [9:0]      home_set;
	logic [4:0]      l3_alias[4];

	inclusive_three_level_fifo_cache_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.line_number(line_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit_level(hit_level),
		.victim_valid(victim_valid),
		.victim_line(victim_line)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	// mostly short gaps, a few long ones, none while calm
	function int gap_len();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function void new_phase();
		home_set = 10'($urandom);
		for (int i = 0; i < 4; i++)
			l3_alias[i] = 5'($urandom);
		for (int i = 0; i < 24; i++)
			tag_pool[i] = line_t'({$urandom, $urandom});
	endfunction

	// mostly lines of a few L3 sets that share one L2 and L1 set
	function line_t pick_line();
		line_t t;
		if ($urandom_range(0, 9) == 0)
			return line_t'({$urandom, $urandom});
		t = tag_pool[$urandom_range(0, 23)];
		return {t[42:0], l3_alias[$urandom_range(0, 3)], home_set};
	endfunction

	task send_access(line_t line);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		line_number <= line;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_access(line);
		@(negedge clk);
	endtask

	task hold_off();
		in_valid <= 0;
		while (sb.outcome_q.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (calm)
			out_stall <= 0;
		else if ($urandom_range(0, 99) < 3)
			out_stall <= 1;
		else if ($urandom_range(0, 99) < 30)
			out_stall <= ~out_stall;
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(hit_level, victim_valid, victim_line);

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 0;
		in_valid = 0;
		line_number = '0;
		out_stall = 0;
		calm = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// extremes, an L1 hit, then an L3 set overflow
		send_access('0);
		send_access('1);
		send_access(line_t'(1));
		send_access(line_t'(1));
		for (int k = 1; k <= 13; k++)
			send_access(line_t'(k) << 15);
		send_access('0);
		send_access('1);
		send_access(line_t'(64));
		send_access(line_t'(1));

		new_phase();
		for (int n = 0; n < 700; n++) begin
			if (n % 100 == 0)
				new_phase();
			if (n % 150 == 0)
				calm = ~calm;
			if (n == 350)
				hold_off();
			send_access(pick_line());
		end
		in_valid <= 0;

		while (sb.outcome_q.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
		if (sb.errors == 0 && sb.outcome_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/itfc_pkg.sv
hdl/itfc_level.sv
hdl/inclusive_three_level_fifo_cache_unit.sv
tb/sv/tb.sv
